// ----- src/coo_to_csr_converter_macros.svh -----
// Assertion macros for the coordinate to compressed sparse row converter
`ifndef COO_TO_CSR_CONVERTER_MACROS_SVH
`define COO_TO_CSR_CONVERTER_MACROS_SVH

// same-cycle implication, reset masked
`define C2C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c2c assertion failed");

// next-cycle implication, reset masked
`define C2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c2c assertion failed");

`endif

// ----- src/c2c_pkg.sv -----
// Shared constants and codes of the coordinate to compressed sparse row converter
package c2c_pkg;

  localparam int unsigned MAX_ROWS    = 256;
  localparam int unsigned MAX_ENTRIES = 1024;

  localparam int unsigned ENT_AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ROW_AW = $clog2(MAX_ROWS + 1);

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_READ_ENT = 2'd1;
  localparam logic [1:0] KIND_READ_PTR = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_IDX  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_RD_RANGE = 3'd3;
  localparam logic [2:0] STAT_NO_CONV  = 3'd4;

endpackage

// ----- src/coo_to_csr_converter.sv -----
// Coordinate to compressed sparse row converter, top level
// Usage:
//   s_axis carries one item per handshake. tuser = kind (0 load, 1 read entry,
//   2 read row pointer), tlast = last entry of the matrix. Every item gives
//   exactly one result on m_axis; tuser there is the status.
//   cfg_* writes the matrix dimension (row_count); write only while idle.
// Answers:
//   A load or a rejected read answers in the cycle after acceptance; an
//   accepted entry or pointer read answers through the registered read port
//   of the packed store or the row pointer store and then the output register.
//   A load marked last runs the conversion before it answers: pointer clear,
//   compaction and counting, prefix sum, scatter, the per-row exchange sort
//   and a finish step; no new item is accepted meanwhile.
//   All walks share one read and one write port per store and one compare.
// Reset clears the entry count and the converted flag; row_count goes to 256.
// If m_axis stalls, the result is held and s_axis accepts only once the
// output register is free or being emptied.
`include "coo_to_csr_converter_macros.svh"

module coo_to_csr_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_row, [15:8] entry_col, [79:16] entry_value, [90:80] read_index
  input  logic [c2c_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_col, [71:8] out_value, [82:72] out_pointer
  output logic [c2c_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import c2c_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_ENT, S_RD_PTR, S_CLR, S_CMP_RD, S_CMP_CHK, S_CMP_INC,
    S_PFX_RD, S_PFX_WR, S_SC_RD, S_SC_CUR, S_SC_WR, S_ROW_RD, S_ROW_GET,
    S_B_START, S_B_LD, S_B_CMP, S_B_END, S_DONE
  } state_e;

  // memories
  logic [79:0]       coord_mem  [MAX_ENTRIES];
  logic [71:0]       packed_mem [MAX_ENTRIES];
  logic [CNT_W-1:0]  rp_mem     [MAX_ROWS+1];
  logic [CNT_W-1:0]  cur_mem    [MAX_ROWS+1];

  logic              coord_we, coord_re, packed_we, packed_re;
  logic              rp_we, rp_re, cur_we, cur_re;
  logic [ENT_AW-1:0] coord_wa, coord_ra, packed_wa, packed_ra;
  logic [ROW_AW-1:0] rp_wa, rp_ra, cur_wa, cur_ra;
  logic [79:0]       coord_wd, coord_rd_q;
  logic [71:0]       packed_wd, packed_rd_q;
  logic [CNT_W-1:0]  rp_wd, rp_rd_q, cur_wd, cur_rd_q;

  always_ff @(posedge clk_i) begin
    if (coord_we) coord_mem[coord_wa] <= coord_wd;
    if (coord_re) coord_rd_q <= coord_mem[coord_ra];
  end

  always_ff @(posedge clk_i) begin
    if (packed_we) packed_mem[packed_wa] <= packed_wd;
    if (packed_re) packed_rd_q <= packed_mem[packed_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rp_we) rp_mem[rp_wa] <= rp_wd;
    if (rp_re) rp_rd_q <= rp_mem[rp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cur_re) cur_rd_q <= cur_mem[cur_ra];
  end

  // control and output registers
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, l_q, l_d, k_q, k_d, sum_q, sum_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic [ROW_AW-1:0] r_q, r_d, conv_rows_q, conv_rows_d;
  logic [8:0]        rowcnt_q, rowcnt_d;
  logic [7:0]        row_q, row_d;
  logic              conv_q, conv_d;
  logic [71:0]       cur_q, cur_d;
  logic [2:0]        ld_stat_q, ld_stat_d;
  logic              ovalid_q, ovalid_d;
  logic [2:0]        ostat_q, ostat_d;
  logic [7:0]        ocol_q, ocol_d;
  logic [63:0]       oval_q, oval_d;
  logic [CNT_W-1:0]  optr_q, optr_d;

  // input fields
  logic [1:0]        in_kind;
  logic [7:0]        in_row, in_col;
  logic [63:0]       in_val;
  logic [CNT_W-1:0]  in_idx;
  logic              accept;
  logic [ROW_AW-1:0] dim;
  logic [CNT_W-1:0]  eff_cnt;
  logic [2:0]        ld_stat;

  assign in_kind = s_axis_tuser;
  assign in_row  = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[15:8];
  assign in_val  = s_axis_tdata[79:16];
  assign in_idx  = s_axis_tdata[90:80];

  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {5'd0, optr_q, oval_q, ocol_q};

  always_comb begin
    if (rowcnt_q == '0) dim = ROW_AW'(1);
    else if (rowcnt_q > 9'(MAX_ROWS)) dim = ROW_AW'(MAX_ROWS);
    else dim = ROW_AW'(rowcnt_q);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    l_d         = l_q;
    k_d         = k_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    r_d         = r_q;
    conv_rows_d = conv_rows_q;
    rowcnt_d    = rowcnt_q;
    row_d       = row_q;
    conv_d      = conv_q;
    cur_d       = cur_q;
    ld_stat_d   = ld_stat_q;
    ovalid_d    = ovalid_q && !m_axis_tready;
    ostat_d     = ostat_q;
    ocol_d      = ocol_q;
    oval_d      = oval_q;
    optr_d      = optr_q;
    eff_cnt     = conv_q ? '0 : cnt_q;
    ld_stat     = STAT_OK;

    coord_we  = 1'b0; coord_wa  = '0; coord_wd  = '0; coord_re  = 1'b0; coord_ra  = '0;
    packed_we = 1'b0; packed_wa = '0; packed_wd = '0; packed_re = 1'b0; packed_ra = '0;
    rp_we     = 1'b0; rp_wa     = '0; rp_wd     = '0; rp_re     = 1'b0; rp_ra     = '0;
    cur_we    = 1'b0; cur_wa    = '0; cur_wd    = '0; cur_re    = 1'b0; cur_ra    = '0;

    if (cfg_valid && cfg_ready) rowcnt_d = cfg_data;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ocol_d = '0;
          oval_d = '0;
          optr_d = '0;
          case (in_kind)
            KIND_LOAD: begin
              conv_d = 1'b0;
              cnt_d  = eff_cnt;
              if ({1'b0, in_row} >= dim || {1'b0, in_col} >= dim) begin
                ld_stat = STAT_BAD_IDX;
              end else if (eff_cnt >= CNT_W'(MAX_ENTRIES)) begin
                ld_stat = STAT_FULL;
              end else begin
                coord_we = 1'b1;
                coord_wa = eff_cnt[ENT_AW-1:0];
                coord_wd = {in_val, in_col, in_row};
                cnt_d    = eff_cnt + CNT_W'(1);
              end
              if (s_axis_tlast) begin
                ld_stat_d = ld_stat;
                r_d       = '0;
                state_d   = S_CLR;
              end else begin
                ovalid_d = 1'b1;
                ostat_d  = ld_stat;
              end
            end
            KIND_READ_ENT: begin
              if (!conv_q) begin
                ovalid_d = 1'b1;
                ostat_d  = STAT_NO_CONV;
              end else if (in_idx >= cnt_q) begin
                ovalid_d = 1'b1;
                ostat_d  = STAT_RD_RANGE;
              end else begin
                packed_re = 1'b1;
                packed_ra = in_idx[ENT_AW-1:0];
                state_d   = S_RD_ENT;
              end
            end
            KIND_READ_PTR: begin
              if (!conv_q) begin
                ovalid_d = 1'b1;
                ostat_d  = STAT_NO_CONV;
              end else if (in_idx > CNT_W'(conv_rows_q)) begin
                ovalid_d = 1'b1;
                ostat_d  = STAT_RD_RANGE;
              end else begin
                rp_re   = 1'b1;
                rp_ra   = in_idx[ROW_AW-1:0];
                state_d = S_RD_PTR;
              end
            end
            default: begin
              ovalid_d = 1'b1;
              ostat_d  = STAT_OK;
            end
          endcase
        end
      end
      S_RD_ENT: begin
        ovalid_d = 1'b1;
        ostat_d  = STAT_OK;
        ocol_d   = packed_rd_q[7:0];
        oval_d   = packed_rd_q[71:8];
        state_d  = S_IDLE;
      end
      S_RD_PTR: begin
        ovalid_d = 1'b1;
        ostat_d  = STAT_OK;
        optr_d   = rp_rd_q;
        state_d  = S_IDLE;
      end
      // clear row pointers and cursors
      S_CLR: begin
        rp_we  = 1'b1;
        rp_wa  = r_q;
        cur_we = 1'b1;
        cur_wa = r_q;
        if (r_q == ROW_AW'(MAX_ROWS)) begin
          l_d     = '0;
          k_d     = '0;
          state_d = S_CMP_RD;
        end else begin
          r_d = r_q + ROW_AW'(1);
        end
      end
      // drop entries outside the dimension, count per row
      S_CMP_RD: begin
        if (l_q == cnt_q) begin
          cnt_d   = k_q;
          r_d     = ROW_AW'(1);
          sum_d   = '0;
          state_d = S_PFX_RD;
        end else begin
          coord_re = 1'b1;
          coord_ra = l_q[ENT_AW-1:0];
          state_d  = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if ({1'b0, coord_rd_q[7:0]} < dim && {1'b0, coord_rd_q[15:8]} < dim) begin
          coord_we = 1'b1;
          coord_wa = k_q[ENT_AW-1:0];
          coord_wd = coord_rd_q;
          rp_re    = 1'b1;
          rp_ra    = {1'b0, coord_rd_q[7:0]} + ROW_AW'(1);
          row_d    = coord_rd_q[7:0];
          state_d  = S_CMP_INC;
        end else begin
          l_d     = l_q + CNT_W'(1);
          state_d = S_CMP_RD;
        end
      end
      S_CMP_INC: begin
        rp_we   = 1'b1;
        rp_wa   = {1'b0, row_q} + ROW_AW'(1);
        rp_wd   = rp_rd_q + CNT_W'(1);
        k_d     = k_q + CNT_W'(1);
        l_d     = l_q + CNT_W'(1);
        state_d = S_CMP_RD;
      end
      // running prefix sum, copied into the cursors
      S_PFX_RD: begin
        rp_re   = 1'b1;
        rp_ra   = r_q;
        state_d = S_PFX_WR;
      end
      S_PFX_WR: begin
        rp_we  = 1'b1;
        rp_wa  = r_q;
        rp_wd  = rp_rd_q + sum_q;
        cur_we = 1'b1;
        cur_wa = r_q;
        cur_wd = rp_rd_q + sum_q;
        sum_d  = rp_rd_q + sum_q;
        if (r_q == dim) begin
          l_d     = '0;
          state_d = S_SC_RD;
        end else begin
          r_d     = r_q + ROW_AW'(1);
          state_d = S_PFX_RD;
        end
      end
      // scatter in load order
      S_SC_RD: begin
        if (l_q == cnt_q) begin
          r_d     = '0;
          lo_d    = '0;
          state_d = S_ROW_RD;
        end else begin
          coord_re = 1'b1;
          coord_ra = l_q[ENT_AW-1:0];
          state_d  = S_SC_CUR;
        end
      end
      S_SC_CUR: begin
        cur_re  = 1'b1;
        cur_ra  = {1'b0, coord_rd_q[7:0]};
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        packed_we = 1'b1;
        packed_wa = cur_rd_q[ENT_AW-1:0];
        packed_wd = {coord_rd_q[79:16], coord_rd_q[15:8]};
        cur_we    = 1'b1;
        cur_wa    = {1'b0, coord_rd_q[7:0]};
        cur_wd    = cur_rd_q + CNT_W'(1);
        l_d       = l_q + CNT_W'(1);
        state_d   = S_SC_RD;
      end
      // per-row exchange sort; the larger column bubbles up in cur_q
      S_ROW_RD: begin
        if (r_q == dim) begin
          state_d = S_DONE;
        end else begin
          rp_re   = 1'b1;
          rp_ra   = r_q + ROW_AW'(1);
          state_d = S_ROW_GET;
        end
      end
      S_ROW_GET: begin
        hi_d = rp_rd_q;
        if (rp_rd_q <= lo_q + CNT_W'(1)) begin
          lo_d    = rp_rd_q;
          r_d     = r_q + ROW_AW'(1);
          state_d = S_ROW_RD;
        end else begin
          i_d     = rp_rd_q - CNT_W'(1);
          state_d = S_B_START;
        end
      end
      S_B_START: begin
        packed_re = 1'b1;
        packed_ra = lo_q[ENT_AW-1:0];
        j_d       = lo_q;
        state_d   = S_B_LD;
      end
      S_B_LD: begin
        cur_d     = packed_rd_q;
        packed_re = 1'b1;
        packed_ra = ENT_AW'(j_q + CNT_W'(1));
        state_d   = S_B_CMP;
      end
      S_B_CMP: begin
        packed_we = 1'b1;
        packed_wa = j_q[ENT_AW-1:0];
        if (cur_q[7:0] > packed_rd_q[7:0]) begin
          packed_wd = packed_rd_q;
        end else begin
          packed_wd = cur_q;
          cur_d     = packed_rd_q;
        end
        j_d = j_q + CNT_W'(1);
        if (j_q + CNT_W'(1) < i_q) begin
          packed_re = 1'b1;
          packed_ra = ENT_AW'(j_q + CNT_W'(2));
        end else begin
          state_d = S_B_END;
        end
      end
      S_B_END: begin
        packed_we = 1'b1;
        packed_wa = i_q[ENT_AW-1:0];
        packed_wd = cur_q;
        i_d       = i_q - CNT_W'(1);
        if (i_q - CNT_W'(1) > lo_q) begin
          state_d = S_B_START;
        end else begin
          lo_d    = hi_q;
          r_d     = r_q + ROW_AW'(1);
          state_d = S_ROW_RD;
        end
      end
      S_DONE: begin
        conv_d      = 1'b1;
        conv_rows_d = dim;
        ovalid_d    = 1'b1;
        ostat_d     = ld_stat_q;
        ocol_d      = '0;
        oval_d      = '0;
        optr_d      = '0;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      conv_q      <= 1'b0;
      conv_rows_q <= ROW_AW'(1);
      rowcnt_q    <= 9'(MAX_ROWS);
      ovalid_q    <= 1'b0;
      l_q         <= '0;
      k_q         <= '0;
      r_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      conv_q      <= conv_d;
      conv_rows_q <= conv_rows_d;
      rowcnt_q    <= rowcnt_d;
      ovalid_q    <= ovalid_d;
      l_q         <= l_d;
      k_q         <= k_d;
      r_q         <= r_d;
      i_q         <= i_d;
      j_q         <= j_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    row_q     <= row_d;
    cur_q     <= cur_d;
    ld_stat_q <= ld_stat_d;
    ostat_q   <= ostat_d;
    ocol_q    <= ocol_d;
    oval_q    <= oval_d;
    optr_q    <= optr_d;
  end

  `C2C_ASSERT_NOW(a_busy_not_ready, state_q != S_IDLE, !s_axis_tready)
  `C2C_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_ENTRIES))
  `C2C_ASSERT_NEXT(a_early_read, accept && in_kind != KIND_LOAD && in_kind != KIND_UNUSED && !conv_q,
                   m_axis_tvalid && m_axis_tuser == STAT_NO_CONV)
  `C2C_ASSERT_NOW(a_sort_window, state_q == S_B_CMP, j_q < i_q && j_q >= lo_q)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the coordinate to compressed sparse row converter
`timescale 1ns / 100ps

module testbench;
  import c2c_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [63:0] value;
    logic        last;
    logic [10:0] idx;
  } matrix_op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  col;
    logic [63:0] value;
    logic [10:0] ptr;
  } answer_t;

  // directed row: either a register write or an item, with an optional typed answer
  typedef struct packed {
    logic       is_cfg;
    logic [8:0] cfg_val;
    matrix_op_t op;
    logic       typed;
    answer_t    ans;
  } directed_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_valid, cfg_ready;
  logic [8:0] cfg_data;

  coo_to_csr_converter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // model of the converter state
  logic [7:0]  coord_row_q [MAX_ENTRIES];
  logic [7:0]  coord_col_q [MAX_ENTRIES];
  logic [63:0] coord_val_q [MAX_ENTRIES];
  logic [7:0]  csr_col_q [MAX_ENTRIES];
  logic [63:0] csr_val_q [MAX_ENTRIES];
  int unsigned row_ptr_q [MAX_ROWS+1];
  int unsigned fill_pos [MAX_ROWS+1];
  int unsigned stored_entries;
  bit          csr_ready;
  int unsigned csr_dim;
  logic [8:0]  dim_reg;

  answer_t pending_answers[$];
  int unsigned errors, accepted_ops, answers_seen, n_loads, n_reads, n_matrices;
  int unsigned idle_cycles;
  int unsigned send_idle_pct, recv_stall_pct;
  bit          hold_req;
  bit          stim_done;

  function automatic int unsigned active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_ROWS) return MAX_ROWS;
    return dim_reg;
  endfunction

  function automatic void build_csr();
    int unsigned n, k, p;
    logic [7:0] tc;
    logic [63:0] tv;
    n = active_dim();
    k = 0;
    for (int unsigned l = 0; l < stored_entries; l++) begin
      if (coord_row_q[l] < n && coord_col_q[l] < n) begin
        coord_row_q[k] = coord_row_q[l];
        coord_col_q[k] = coord_col_q[l];
        coord_val_q[k] = coord_val_q[l];
        k++;
      end
    end
    stored_entries = k;
    for (int r = 0; r <= MAX_ROWS; r++) row_ptr_q[r] = 0;
    for (int unsigned l = 0; l < stored_entries; l++) row_ptr_q[coord_row_q[l] + 1]++;
    for (int unsigned r = 0; r < n; r++) row_ptr_q[r+1] += row_ptr_q[r];
    for (int r = 0; r <= MAX_ROWS; r++) fill_pos[r] = row_ptr_q[r];
    for (int unsigned l = 0; l < stored_entries; l++) begin
      p = fill_pos[coord_row_q[l]];
      if (p < MAX_ENTRIES) begin
        csr_col_q[p] = coord_col_q[l];
        csr_val_q[p] = coord_val_q[l];
      end
      fill_pos[coord_row_q[l]] = p + 1;
    end
    // stable exchange sort inside each row
    for (int unsigned r = 0; r < n; r++) begin
      if (row_ptr_q[r+1] > row_ptr_q[r] + 1) begin
        for (int unsigned i = row_ptr_q[r+1] - 1; i > row_ptr_q[r]; i--) begin
          for (int unsigned j = row_ptr_q[r]; j < i; j++) begin
            if (csr_col_q[j] > csr_col_q[j+1]) begin
              tc = csr_col_q[j]; tv = csr_val_q[j];
              csr_col_q[j] = csr_col_q[j+1]; csr_val_q[j] = csr_val_q[j+1];
              csr_col_q[j+1] = tc; csr_val_q[j+1] = tv;
            end
          end
        end
      end
    end
    csr_dim = n;
    csr_ready = 1;
  endfunction

  function automatic answer_t predict_answer(matrix_op_t op);
    answer_t a;
    int unsigned n;
    a = '0;
    case (op.kind)
      KIND_LOAD: begin
        n = active_dim();
        if (csr_ready) begin
          csr_ready = 0;
          stored_entries = 0;
        end
        if (op.row >= n || op.col >= n) a.status = STAT_BAD_IDX;
        else if (stored_entries >= MAX_ENTRIES) a.status = STAT_FULL;
        else begin
          coord_row_q[stored_entries] = op.row;
          coord_col_q[stored_entries] = op.col;
          coord_val_q[stored_entries] = op.value;
          stored_entries++;
        end
        if (op.last) build_csr();
      end
      KIND_READ_ENT: begin
        if (!csr_ready) a.status = STAT_NO_CONV;
        else if (op.idx >= stored_entries || op.idx >= MAX_ENTRIES) a.status = STAT_RD_RANGE;
        else begin
          a.col = csr_col_q[op.idx];
          a.value = csr_val_q[op.idx];
        end
      end
      KIND_READ_PTR: begin
        if (!csr_ready) a.status = STAT_NO_CONV;
        else if (op.idx > csr_dim || op.idx > MAX_ROWS) a.status = STAT_RD_RANGE;
        else a.ptr = 11'(row_ptr_q[op.idx]);
      end
      default: a = '0;
    endcase
    return a;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // result checker
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.col    = m_axis_tdata[7:0];
      got.value  = m_axis_tdata[71:8];
      got.ptr    = m_axis_tdata[82:72];
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with no item outstanding: status %0d", got.status);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, got.col); errors++;
        end
        if (got.value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, got.value); errors++;
        end
        if (got.ptr !== want.ptr) begin
          $error("out_pointer: expected %0d, got %0d", want.ptr, got.ptr); errors++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_cnt = 0;
        m_axis_tready <= 1'b0;
        while (hold_cnt < 400) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        hold_req = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_op(matrix_op_t op, bit typed, answer_t typed_ans);
    int unsigned gap;
    answer_t a;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.kind;
    s_axis_tlast  <= op.last;
    s_axis_tdata  <= {5'd0, op.idx, op.value, op.col, op.row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    a = predict_answer(op);
    pending_answers.push_back(typed ? typed_ans : a);
    accepted_ops++;
    if (op.kind == KIND_LOAD) n_loads++;
    else if (op.kind != KIND_UNUSED) n_reads++;
    if (op.kind == KIND_LOAD && op.last) n_matrices++;
  endtask

  task automatic write_dim(logic [8:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    dim_reg = v;
  endtask

  function automatic matrix_op_t mk(logic [1:0] k, logic [7:0] r, logic [7:0] c,
                                    logic [63:0] v, logic l, logic [10:0] i);
    matrix_op_t op;
    op.kind = k; op.row = r; op.col = c; op.value = v; op.last = l; op.idx = i;
    return op;
  endfunction

  function automatic directed_row_t drow(matrix_op_t op, bit typed, logic [2:0] st);
    directed_row_t d;
    d = '0;
    d.op = op; d.typed = typed; d.ans.status = st;
    return d;
  endfunction

  function automatic directed_row_t dcfg(logic [8:0] v);
    directed_row_t d;
    d = '0;
    d.is_cfg = 1; d.cfg_val = v;
    return d;
  endfunction

  // one random item of a matrix-building sequence
  function automatic matrix_op_t rand_load(int unsigned n, bit last);
    logic [7:0] r, c;
    if ($urandom_range(99) < 8) begin
      r = 8'($urandom_range(255)); c = 8'($urandom_range(255));
    end else begin
      r = 8'($urandom_range(n - 1)); c = 8'($urandom_range(n - 1));
    end
    return mk(KIND_LOAD, r, c, {$urandom, $urandom}, last, 11'($urandom_range(2047)));
  endfunction

  function automatic matrix_op_t rand_read(int unsigned n);
    int unsigned pick;
    logic [10:0] i;
    pick = $urandom_range(99);
    if (pick < 5) return mk(KIND_UNUSED, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                            1'($urandom_range(1)), 11'($urandom_range(2047)));
    if (pick < 55)
      i = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                   : 11'($urandom_range(stored_entries));
    else
      i = ($urandom_range(9) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(n + 1));
    return mk(pick < 55 ? KIND_READ_ENT : KIND_READ_PTR, 8'($urandom), 8'($urandom),
              {$urandom, $urandom}, 1'($urandom_range(1)), i);
  endfunction

  initial begin
    directed_row_t plan[$];
    int unsigned n, budget, loads_left;
    int unsigned mode_send[4] = '{0, 65, 0, 25};
    int unsigned mode_recv[4] = '{0, 0, 65, 25};
    logic [8:0]  phase_dim[4] = '{9'd1, 9'd256, 9'd17, 9'd3};
    answer_t unused_ans;

    rst_ni = 0;
    s_axis_tvalid <= 0; s_axis_tdata <= '0; s_axis_tlast <= 0; s_axis_tuser <= '0;
    cfg_valid <= 0; cfg_data <= '0;
    errors = 0; accepted_ops = 0; answers_seen = 0; n_loads = 0; n_reads = 0;
    n_matrices = 0; idle_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 0; stim_done = 0;
    for (int l = 0; l < MAX_ENTRIES; l++) begin
      coord_row_q[l] = 0; coord_col_q[l] = 0; coord_val_q[l] = 0;
      csr_col_q[l] = 0; csr_val_q[l] = 0;
    end
    for (int r = 0; r <= MAX_ROWS; r++) row_ptr_q[r] = 0;
    stored_entries = 0; csr_ready = 0; csr_dim = 1; dim_reg = 9'd256;
    repeat (9) @(posedge clk_i);
    rst_ni = 1;
    @(posedge clk_i);

    // directed part
    plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 0), 1, STAT_NO_CONV));
    plan.push_back(drow(mk(KIND_READ_PTR, 0, 0, 0, 0, 0), 1, STAT_NO_CONV));
    plan.push_back(drow(mk(KIND_UNUSED, 8'hFF, 8'hFF, '1, 1, 11'h7FF), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_LOAD, 0, 255, '1, 0, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_LOAD, 255, 0, 64'h0, 0, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_LOAD, 5, 7, 64'hA5A5_0000_0000_0001, 0, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_LOAD, 5, 3, 64'h0000_0000_0000_00B0, 0, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_LOAD, 5, 3, 64'h0000_0000_0000_00C0, 0, 0), 1, STAT_OK));
    // lowering the dimension drops entries at row or column 255
    plan.push_back(dcfg(9'd200));
    plan.push_back(drow(mk(KIND_LOAD, 5, 1, 64'h8000_0000_0000_0000, 1, 0), 1, STAT_OK));
    for (int i = 0; i < 4; i++)
      plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 11'(i)), 0, 0));
    plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 4), 1, STAT_RD_RANGE));
    plan.push_back(drow(mk(KIND_READ_PTR, 0, 0, 0, 0, 200), 0, 0));
    plan.push_back(drow(mk(KIND_READ_PTR, 0, 0, 0, 0, 201), 1, STAT_RD_RANGE));
    plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 11'h7FF), 1, STAT_RD_RANGE));
    plan.push_back(dcfg(9'd0));  // acts as 1
    plan.push_back(drow(mk(KIND_LOAD, 1, 0, 64'h1, 0, 0), 1, STAT_BAD_IDX));
    plan.push_back(drow(mk(KIND_LOAD, 0, 0, 64'h2, 1, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_READ_PTR, 0, 0, 0, 0, 1), 0, 0));
    plan.push_back(dcfg(9'd511));  // clipped to the maximum
    plan.push_back(drow(mk(KIND_LOAD, 255, 255, '1, 1, 0), 1, STAT_OK));
    plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 0), 0, 0));
    plan.push_back(dcfg(9'd8));
    // dropped entry still carries the last mark: empty matrix
    plan.push_back(drow(mk(KIND_LOAD, 8, 0, 64'h3, 1, 0), 1, STAT_BAD_IDX));
    plan.push_back(drow(mk(KIND_READ_ENT, 0, 0, 0, 0, 0), 1, STAT_RD_RANGE));
    plan.push_back(drow(mk(KIND_READ_PTR, 0, 0, 0, 0, 8), 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_dim(plan[i].cfg_val);
      else send_op(plan[i].op, plan[i].typed, plan[i].ans);
    end

    unused_ans = '0;
    // random phases: small matrices, reads, some noise
    for (int ph = 0; ph < 4; ph++) begin
      write_dim(phase_dim[ph]);
      send_idle_pct = mode_send[ph];
      recv_stall_pct = mode_recv[ph];
      n = active_dim();
      budget = 0;
      if (ph == 0) hold_req = 1;
      while (budget < 70) begin
        loads_left = $urandom_range(1, 30);
        while (loads_left > 0) begin
          if ($urandom_range(99) < 5) send_op(rand_read(n), 0, unused_ans);
          else begin
            send_op(rand_load(n, loads_left == 1), 0, unused_ans);
            loads_left--;
          end
          budget++;
        end
        repeat ($urandom_range(3, 12)) begin
          send_op(rand_read(n), 0, unused_ans);
          budget++;
        end
      end
    end

    // full store: one large matrix spread over all rows
    write_dim(9'd256);
    send_idle_pct = 0;
    recv_stall_pct = 10;
    for (int l = 0; l < MAX_ENTRIES + 6; l++)
      send_op(rand_load(256, l == MAX_ENTRIES + 5), 0, unused_ans);
    repeat (12) send_op(rand_read(256), 0, unused_ans);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items: %0d loads, %0d reads, %0d conversions, %0d results.",
             accepted_ops, n_loads, n_reads, n_matrices, answers_seen);
    $display("Dimensions 0 to 511 incl. clipping, full store, stalls and a long hold-off.");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
